/* rtl/core/esc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, codes and types of the entangled set closure block.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int QUBITS    = 512;
    localparam int MAX_EDGES = 1024;
    localparam int WORDS     = (QUBITS + 63) / 64;

    localparam int QF_W = 9;                         // qubit field width
    localparam int QB_W = $clog2(QUBITS);            // node memory address
    localparam int EA_W = $clog2(MAX_EDGES);         // edge memory address
    localparam int EC_W = $clog2(MAX_EDGES + 1);     // edge count

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 136;

    localparam logic [1:0] CMD_SET_KIND = 2'd0;
    localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;

    localparam logic [2:0] KIND_X       = 3'd0;
    localparam logic [2:0] KIND_Y       = 3'd1;
    localparam logic [2:0] KIND_BLOCK   = 3'd3;
    localparam logic [2:0] KIND_NEITHER = 3'd4;

    typedef struct packed {
        logic       active;
        logic [2:0] kind;
    } node_t;

    typedef struct packed {
        logic [QB_W-1:0] b;
        logic [QB_W-1:0] a;
    } edge_t;

endpackage

/* rtl/core/entangled_set_closure_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entangled_set_closure_top
// Loads qubit kinds and two-qubit edges, then on compute grows the active set
// from block qubits and X/Y edge endpoints along the edges until it is closed,
// and streams it out as 64-bit mask words.
//
//   channel  | direction | signals                        | word
//   ---------+-----------+--------------------------------+-------------------
//   s_       | in        | s_tvalid s_tready s_tdata      | one command
//   m_       | out       | m_tvalid m_tready m_tdata      | one mask word
//            |           | m_tlast                        |
//
// compute: each qubit is read and rewritten to seed block qubits, then
//   each stored edge is read and its ends are read and written back, on every
//   pass (one seed pass plus propagation passes until a pass changes nothing),
//   then 64 qubits are gathered per mask word and the output is loaded, all
//   bound by the node memory port
// after reset a clearing pass writes every kind to neither
// a held output word lets the next word be gathered; the block waits in the
//   push step only when a second word is ready before the first was taken
// ----------------------------------------------------------------------------
module entangled_set_closure_top
    import esc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // command, qubit_a, qubit_b, kind, pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // word_index, active_bits, block_bits,
                                            // edges_dropped, pad
    output logic                 m_tlast
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_IRD  = 4'd2;
    localparam logic [3:0] S_IWR  = 4'd3;
    localparam logic [3:0] S_EDGE = 4'd4;
    localparam logic [3:0] S_RA   = 4'd5;
    localparam logic [3:0] S_RB   = 4'd6;
    localparam logic [3:0] S_WA   = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_GRD  = 4'd9;
    localparam logic [3:0] S_GCAP = 4'd10;
    localparam logic [3:0] S_PUSH = 4'd11;

    localparam logic [QF_W:0]   QUBITS_V  = (QF_W + 1)'(QUBITS);
    localparam logic [QB_W-1:0] Q_LAST    = QB_W'(QUBITS - 1);
    localparam logic [EC_W-1:0] EDGES_MAX = EC_W'(MAX_EDGES);
    localparam logic [2:0]      W_LAST    = 3'(WORDS - 1);

    logic [3:0]           state_reg, state_next;
    logic [QB_W-1:0]      q_reg, q_next;
    logic [EC_W-1:0]      e_reg, e_next;
    logic [EC_W-1:0]      edge_count_reg, edge_count_next;
    logic                 ovf_reg, ovf_next;
    logic                 seed_reg, seed_next;
    logic                 chg_reg, chg_next;
    logic [2:0]           w_reg, w_next;
    logic [5:0]           g_reg, g_next;
    node_t                na_reg, na_next;
    node_t                nb_reg, nb_next;
    logic [63:0]          act_sr_reg, act_sr_next;
    logic [63:0]          blk_sr_reg, blk_sr_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic [1:0]      in_cmd;
    logic [QF_W-1:0] in_qa;
    logic [QF_W-1:0] in_qb;
    logic [2:0]      in_kind;
    logic            in_fire;
    logic            qa_ok, qb_ok;

    logic            node_we, node_re;
    logic [QB_W-1:0] node_waddr, node_raddr;
    node_t           node_wdata, node_rdata;
    logic            edge_we, edge_re;
    logic [EA_W-1:0] edge_waddr;
    edge_t           edge_wdata, edge_rdata;

    logic [EC_W-1:0] e_inc;
    logic [8:0]      g_addr;
    logic            g_in_range;
    logic            act_a, act_b, new_a, new_b;

    assign in_cmd  = s_tdata[1:0];
    assign in_qa   = s_tdata[10:2];
    assign in_qb   = s_tdata[19:11];
    assign in_kind = s_tdata[22:20];

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign qa_ok    = {1'b0, in_qa} < QUBITS_V;
    assign qb_ok    = {1'b0, in_qb} < QUBITS_V;

    assign e_inc      = e_reg + EC_W'(1);
    assign g_addr     = {w_reg, g_reg};
    assign g_in_range = {1'b0, g_addr} < QUBITS_V;

    // edge update: seed pass marks x/y endpoints, later passes spread marks
    assign act_a = na_reg.active;
    assign act_b = node_rdata.active;
    assign new_a = seed_reg ? (act_a || na_reg.kind == KIND_X || na_reg.kind == KIND_Y)
                            : (act_a || act_b);
    assign new_b = seed_reg ? (act_b || node_rdata.kind == KIND_X
                                     || node_rdata.kind == KIND_Y)
                            : (act_a || act_b);

    always_comb begin
        state_next      = state_reg;
        q_next          = q_reg;
        e_next          = e_reg;
        edge_count_next = edge_count_reg;
        ovf_next        = ovf_reg;
        seed_next       = seed_reg;
        chg_next        = chg_reg;
        w_next          = w_reg;
        g_next          = g_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        act_sr_next     = act_sr_reg;
        blk_sr_next     = blk_sr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;

        node_we    = 1'b0;
        node_waddr = q_reg;
        node_wdata = '{active: 1'b0, kind: KIND_NEITHER};
        node_re    = 1'b0;
        node_raddr = q_reg;
        edge_we    = 1'b0;
        edge_waddr = edge_count_reg[EA_W-1:0];
        edge_wdata = '{b: in_qb[QB_W-1:0], a: in_qa[QB_W-1:0]};
        edge_re    = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                node_we = 1'b1;
                q_next  = q_reg + QB_W'(1);
                if (q_reg == Q_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (in_cmd)
                        CMD_SET_KIND: begin
                            node_we    = qa_ok;
                            node_waddr = in_qa[QB_W-1:0];
                            node_wdata = '{active: 1'b0, kind: in_kind};
                        end
                        CMD_ADD_EDGE: begin
                            if (qa_ok && qb_ok) begin
                                if (edge_count_reg >= EDGES_MAX) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    edge_we         = 1'b1;
                                    edge_count_next = edge_count_reg + EC_W'(1);
                                end
                            end
                        end
                        CMD_COMPUTE: begin
                            q_next     = '0;
                            w_next     = '0;
                            g_next     = '0;
                            state_next = S_IRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_IRD: begin
                node_re    = 1'b1;
                state_next = S_IWR;
            end
            S_IWR: begin
                node_we    = 1'b1;
                node_wdata = '{active: (node_rdata.kind == KIND_BLOCK),
                               kind: node_rdata.kind};
                q_next     = q_reg + QB_W'(1);
                state_next = S_IRD;
                if (q_reg == Q_LAST) begin
                    e_next     = '0;
                    seed_next  = 1'b1;
                    chg_next   = 1'b0;
                    state_next = (edge_count_reg == '0) ? S_GRD : S_EDGE;
                end
            end
            S_EDGE: begin
                edge_re    = 1'b1;
                state_next = S_RA;
            end
            S_RA: begin
                node_re    = 1'b1;
                node_raddr = edge_rdata.a;
                state_next = S_RB;
            end
            S_RB: begin
                node_re    = 1'b1;
                node_raddr = edge_rdata.b;
                na_next    = node_rdata;
                state_next = S_WA;
            end
            S_WA: begin
                node_we    = 1'b1;
                node_waddr = edge_rdata.a;
                node_wdata = '{active: new_a, kind: na_reg.kind};
                nb_next    = '{active: new_b, kind: node_rdata.kind};
                if (!seed_reg && act_a != act_b) begin
                    chg_next = 1'b1;
                end
                state_next = S_WB;
            end
            S_WB: begin
                node_we    = 1'b1;
                node_waddr = edge_rdata.b;
                node_wdata = nb_reg;
                e_next     = e_inc;
                state_next = S_EDGE;
                if (e_inc == edge_count_reg) begin
                    e_next    = '0;
                    seed_next = 1'b0;
                    chg_next  = 1'b0;
                    if (!seed_reg && !chg_reg) begin
                        state_next = S_GRD;
                    end
                end
            end
            S_GRD: begin
                node_re    = 1'b1;
                node_raddr = g_addr[QB_W-1:0];
                state_next = S_GCAP;
            end
            S_GCAP: begin
                act_sr_next = {g_in_range && node_rdata.active, act_sr_reg[63:1]};
                blk_sr_next = {g_in_range && node_rdata.kind == KIND_BLOCK,
                               blk_sr_reg[63:1]};
                g_next      = g_reg + 6'd1;
                state_next  = (g_reg == 6'd63) ? S_PUSH : S_GRD;
            end
            S_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, ovf_reg, blk_sr_reg, act_sr_reg, w_reg};
                    m_tlast_next  = (w_reg == W_LAST);
                    w_next        = w_reg + 3'd1;
                    state_next    = S_GRD;
                    if (w_reg == W_LAST) begin
                        edge_count_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            q_reg          <= '0;
            edge_count_reg <= '0;
            ovf_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            q_reg          <= q_next;
            edge_count_reg <= edge_count_next;
            ovf_reg        <= ovf_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg       <= e_next;
        seed_reg    <= seed_next;
        chg_reg     <= chg_next;
        w_reg       <= w_next;
        g_reg       <= g_next;
        na_reg      <= na_next;
        nb_reg      <= nb_next;
        act_sr_reg  <= act_sr_next;
        blk_sr_reg  <= blk_sr_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    esc_ram #(
        .WIDTH($bits(node_t)),
        .DEPTH(QUBITS)
    ) u_node_ram (
        .aclk   (aclk),
        .wr_en  (node_we),
        .wr_addr(node_waddr),
        .wr_data(node_wdata),
        .rd_en  (node_re),
        .rd_addr(node_raddr),
        .rd_data(node_rdata)
    );

    esc_ram #(
        .WIDTH($bits(edge_t)),
        .DEPTH(MAX_EDGES)
    ) u_edge_ram (
        .aclk   (aclk),
        .wr_en  (edge_we),
        .wr_addr(edge_waddr),
        .wr_data(edge_wdata),
        .rd_en  (edge_re),
        .rd_addr(e_reg[EA_W-1:0]),
        .rd_data(edge_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/core/esc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module esc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/esc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of the entangled set closure block, bound to the top.
// ----------------------------------------------------------------------------
module esc_checker
    import esc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // compute closes the input in the cycle after it is accepted
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == CMD_COMPUTE |=> !s_tready)
        else $error("input open right after compute");

    // last word of a run carries the top word index
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[2:0] == 3'(WORDS - 1))
        else $error("last word has wrong index");

    // block qubits are always active
    a_block_in_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[130:67] & ~m_tdata[66:3]) == 64'd0)
        else $error("block bit outside active set");

endmodule

bind entangled_set_closure_top esc_checker u_esc_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the entangled set closure block. Commands go in on
// the s_ stream in random bursts while the m_ side stalls in shifting
// patterns. A scoreboard keeps its own kind table and edge list and works out
// the closed active set on every compute. Each mask word that comes out is
// checked field by field against the oldest word still due.
// ----------------------------------------------------------------------------
module tb_top;
    import esc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] KIND_Z     = 3'd2;
    localparam int RANDOM_ITEMS  = 160;
    localparam int OVERFLOW_ADDS = MAX_EDGES + 6;
    localparam int STALL_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 300;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    typedef struct {
        logic [2:0]  index;
        logic [63:0] active;
        logic [63:0] blocks;
        logic        dropped;
        logic        last;
    } mask_word_t;

    class closure_scoreboard;
        logic [2:0]      kind_of [QUBITS];
        logic [QB_W-1:0] end_a [$];
        logic [QB_W-1:0] end_b [$];
        logic            dropped;
        mask_word_t      words_due [$];
        int              mismatch_count;

        function new();
            foreach (kind_of[q]) kind_of[q] = KIND_NEITHER;
            dropped = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        function void predict_closure();
            logic [QUBITS-1:0] marks;
            logic [QUBITS-1:0] blocks;
            logic              grew;
            mask_word_t        w;
            for (int q = 0; q < QUBITS; q++) begin
                blocks[q] = (kind_of[q] == KIND_BLOCK);
            end
            marks = blocks;
            foreach (end_a[e]) begin
                if (kind_of[end_a[e]] inside {KIND_X, KIND_Y}) marks[end_a[e]] = 1'b1;
                if (kind_of[end_b[e]] inside {KIND_X, KIND_Y}) marks[end_b[e]] = 1'b1;
            end
            grew = 1'b1;
            while (grew) begin
                grew = 1'b0;
                foreach (end_a[e]) begin
                    if (marks[end_a[e]] != marks[end_b[e]]) begin
                        marks[end_a[e]] = 1'b1;
                        marks[end_b[e]] = 1'b1;
                        grew = 1'b1;
                    end
                end
            end
            for (int i = 0; i < WORDS; i++) begin
                w.index   = 3'(i);
                w.active  = marks[i*64 +: 64];
                w.blocks  = blocks[i*64 +: 64];
                w.dropped = dropped;
                w.last    = (i == WORDS - 1);
                words_due = {words_due, w};
            end
            end_a.delete();
            end_b.delete();
            dropped = 1'b0;
        endfunction

        function void note_command(logic [S_TDATA_W-1:0] d);
            logic [1:0] cmd;
            logic [8:0] qa;
            logic [8:0] qb;
            logic [2:0] kd;
            cmd = d[1:0];
            qa  = d[10:2];
            qb  = d[19:11];
            kd  = d[22:20];
            case (cmd)
                CMD_SET_KIND: begin
                    if (qa < QUBITS) kind_of[qa] = kd;
                end
                CMD_ADD_EDGE: begin
                    if (qa < QUBITS && qb < QUBITS) begin
                        if (end_a.size() >= MAX_EDGES) begin
                            dropped = 1'b1;
                        end else begin
                            end_a = {end_a, QB_W'(qa)};
                            end_b = {end_b, QB_W'(qb)};
                        end
                    end
                end
                CMD_COMPUTE: predict_closure();
                default: ;
            endcase
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatch_count++;
                $display("%0t: mask word %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
            end
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] d, logic lst);
            mask_word_t w;
            if (words_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected mask word, expected none, actual %h", $time, d);
                return;
            end
            w = words_due.pop_front();
            report("word_index", 64'(w.index), 64'(d[2:0]));
            report("active_bits", w.active, d[66:3]);
            report("block_bits", w.blocks, d[130:67]);
            report("edges_dropped", 64'(w.dropped), 64'(d[131]));
            report("last", 64'(w.last), 64'(lst));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    closure_scoreboard closure_sb = new();
    int       burst_left = 0;
    int       item_count = 0;
    int       idle_cycles = 0;
    int       rx_left = 0;
    rx_mode_e rx_mode = RX_OPEN;

    entangled_set_closure_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) closure_sb.check_word(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_command(logic [1:0] cmd, logic [8:0] qa, logic [8:0] qb,
                                logic [2:0] kd);
        logic [S_TDATA_W-1:0] d;
        d = {1'b0, kd, qb, qa, cmd};
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        closure_sb.note_command(d);
        burst_left--;
        item_count++;
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (closure_sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic logic [8:0] pick_qubit(int base, int span);
        return 9'((base + $urandom_range(0, span)) % QUBITS);
    endfunction

    task automatic random_round();
        int base;
        int span;
        int n_kinds;
        int n_edges;
        base    = $urandom_range(0, QUBITS - 1);
        span    = $urandom_range(4, 80);
        n_kinds = $urandom_range(0, 10);
        n_edges = $urandom_range(0, 20);
        repeat (n_kinds) begin
            send_command(CMD_SET_KIND, pick_qubit(base, span), 9'($urandom_range(0, 511)),
                         3'($urandom_range(0, 7)));
        end
        repeat (n_edges) begin
            if ($urandom_range(0, 15) == 0) begin
                send_command(CMD_UNUSED, 9'($urandom_range(0, 511)),
                             9'($urandom_range(0, 511)), 3'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 7) == 0) begin
                send_command(CMD_ADD_EDGE, 9'($urandom_range(0, 511)),
                             9'($urandom_range(0, 511)), 3'($urandom_range(0, 7)));
            end else begin
                send_command(CMD_ADD_EDGE, pick_qubit(base, span), pick_qubit(base, span),
                             3'($urandom_range(0, 7)));
            end
        end
        if ($urandom_range(0, 5) == 0) pause_until_drained();
        if ($urandom_range(0, 4) != 0) begin
            send_command(CMD_COMPUTE, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                         3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // everything neither, nothing stored
        send_command(CMD_COMPUTE, 9'd0, 9'd0, 3'd0);
        send_command(CMD_SET_KIND, 9'd0, 9'd511, KIND_X);
        send_command(CMD_SET_KIND, 9'd511, 9'd0, KIND_Y);
        send_command(CMD_SET_KIND, 9'd64, 9'd0, KIND_Z);
        send_command(CMD_SET_KIND, 9'd63, 9'd0, KIND_BLOCK);
        send_command(CMD_SET_KIND, 9'd200, 9'd0, KIND_NEITHER + 3'd3);
        send_command(CMD_SET_KIND, 9'd201, 9'd0, KIND_NEITHER + 3'd1);
        send_command(CMD_SET_KIND, 9'd202, 9'd0, KIND_NEITHER + 3'd2);
        send_command(CMD_SET_KIND, 9'd300, 9'd0, KIND_NEITHER);
        send_command(CMD_SET_KIND, 9'd128, 9'd0, KIND_X);
        send_command(CMD_SET_KIND, 9'd129, 9'd0, KIND_Y);
        send_command(CMD_ADD_EDGE, 9'd0, 9'd64, 3'd7);
        send_command(CMD_ADD_EDGE, 9'd511, 9'd200, 3'd0);
        send_command(CMD_ADD_EDGE, 9'd202, 9'd200, 3'd0);
        send_command(CMD_ADD_EDGE, 9'd300, 9'd301, 3'd0);
        send_command(CMD_ADD_EDGE, 9'd128, 9'd128, 3'd0);
        send_command(CMD_ADD_EDGE, 9'd302, 9'd63, 3'd0);
        send_command(CMD_UNUSED, 9'd511, 9'd511, 3'd7);
        send_command(CMD_COMPUTE, 9'd511, 9'd511, 3'd7);
        // edges were cleared, so only block qubits remain
        send_command(CMD_COMPUTE, 9'd0, 9'd0, 3'd0);
        pause_until_drained();

        // fill the edge store past capacity on a few qubits
        for (int q = 10; q < 14; q++) begin
            send_command(CMD_SET_KIND, 9'(q), 9'd0, 3'($urandom_range(0, 4)));
        end
        for (int i = 0; i < OVERFLOW_ADDS; i++) begin
            send_command(CMD_ADD_EDGE, 9'($urandom_range(10, 13)), 9'($urandom_range(10, 13)),
                         3'($urandom_range(0, 7)));
        end
        send_command(CMD_COMPUTE, 9'd0, 9'd0, 3'd0);

        item_count = 0;
        while (item_count < RANDOM_ITEMS) random_round();
        send_command(CMD_COMPUTE, 9'd0, 9'd0, 3'd0);
        s_tvalid <= 1'b0;

        while (closure_sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (closure_sb.mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
